FILE: rtl/ohl_pkg.sv
// Shared types and constants for the ordered handle list.
package ohl_pkg;

   localparam int TYPE_W   = 2;
   localparam int HANDLE_W = 32;
   localparam int STATUS_W = 2;
   localparam int POS_W    = 10;
   localparam int COUNT_W  = 11;
   localparam int CFG_W    = 11;
   localparam int DATA_W   = 32;
   localparam int ADDR_W   = 3;

   localparam logic [TYPE_W-1:0] OP_APPEND = 2'd0;
   localparam logic [TYPE_W-1:0] OP_REMOVE = 2'd1;
   localparam logic [TYPE_W-1:0] OP_SEARCH = 2'd2;

   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
   localparam logic [STATUS_W-1:0] ST_NULL      = 2'd2;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

   localparam logic [0:0] REG_CAPACITY   = 1'b0;
   localparam logic [0:0] REG_WARN_LEVEL = 1'b1;

   localparam logic [CFG_W-1:0] CFG_RESET = 11'd512;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic valid;
      logic found;
   } tok_type;

   typedef struct packed {
      logic write_en;
      logic shift_en;
   } cmd_type;

endpackage

FILE: rtl/ordered_handle_list.sv
// Ordered handle list built as a row of DEPTH cells, one stored entry per cell.
// Append and unused request types: the finish state registers the result once the output is free.
// Remove and search: a token walks the whole row, one cell a cycle, and the finish state follows
// once it leaves the last cell; the compaction of a remove is a single parallel shift there. No new
// request is taken until the block is back in idle.
// Synchronous active-high reset empties the list and loads 512 into both registers;
// the cells are not cleared, as only entries below the count are ever compared.
module ordered_handle_list #(
   parameter int DEPTH       = 1024,
   parameter int HANDLE_BITS = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [ohl_pkg::TYPE_W-1:0]     req_type,
   input  logic [ohl_pkg::HANDLE_W-1:0]   req_handle,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [ohl_pkg::STATUS_W-1:0]   rsp_status,
   output logic [ohl_pkg::POS_W-1:0]      rsp_position,
   output logic [ohl_pkg::COUNT_W-1:0]    rsp_count,
   output logic                           rsp_over_warn,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [ohl_pkg::ADDR_W-1:0]     csr_paddr,
   input  logic [ohl_pkg::DATA_W-1:0]     csr_pwdata,
   output logic [ohl_pkg::DATA_W-1:0]     csr_prdata,
   output logic                           csr_pready
);
   import ohl_pkg::*;

   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

   state_type              state_ff;
   state_type              state_in;
   logic [TYPE_W-1:0]      op_ff;
   logic [HANDLE_BITS-1:0] key_ff;
   logic                   launch_ff;
   logic                   found_ff;
   logic [IDX_W-1:0]       pos_ff;
   logic [CNT_W-1:0]       count_ff;
   logic [CNT_W-1:0]       count_in;
   logic [CFG_W-1:0]       capacity_ff;
   logic [CFG_W-1:0]       warn_ff;

   logic                   rsp_valid_ff;
   logic [STATUS_W-1:0]    rsp_status_ff;
   logic [POS_W-1:0]       rsp_position_ff;
   logic [COUNT_W-1:0]     rsp_count_ff;
   logic                   rsp_over_warn_ff;

   logic                   req_accept;
   logic                   out_free;
   logic                   do_finish;
   logic                   full;
   logic [STATUS_W-1:0]    status_in;
   logic [IDX_W-1:0]       result_pos;
   logic                   over_warn_in;
   cmd_type                cmd;
   logic [IDX_W-1:0]       cmd_idx;
   logic                   csr_write;

   tok_type                tok_chain [DEPTH+1];
   logic [HANDLE_BITS-1:0] key_chain [DEPTH+1];
   logic [IDX_W-1:0]       pos_chain [DEPTH+1];
   logic [HANDLE_BITS-1:0] entry_q   [DEPTH];

   // Configuration port.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CFG_RESET;
         warn_ff     <= CFG_RESET;
      end else if (csr_write) begin
         unique case (csr_paddr[2:2])
            REG_CAPACITY:   capacity_ff <= csr_pwdata[CFG_W-1:0];
            REG_WARN_LEVEL: warn_ff     <= csr_pwdata[CFG_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2:2])
         REG_CAPACITY:   csr_prdata = DATA_W'(capacity_ff);
         REG_WARN_LEVEL: csr_prdata = DATA_W'(warn_ff);
         default:        csr_prdata = '0;
      endcase
   end

   // Cell row.
   assign tok_chain[0].valid = launch_ff;
   assign tok_chain[0].found = 1'b0;
   assign key_chain[0]       = key_ff;
   assign pos_chain[0]       = '0;

   for (genvar j = 0; j < DEPTH; j++) begin : g_cell
      logic [HANDLE_BITS-1:0] next_entry;
      if (j < DEPTH - 1) begin : g_mid
         assign next_entry = entry_q[j+1];
      end else begin : g_last
         assign next_entry = entry_q[j];
      end
      ohl_cell #(
         .CELL_IDX    (j),
         .IDX_W       (IDX_W),
         .CNT_W       (CNT_W),
         .HANDLE_BITS (HANDLE_BITS)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .tok_in     (tok_chain[j]),
         .key_in     (key_chain[j]),
         .pos_in     (pos_chain[j]),
         .tok_out    (tok_chain[j+1]),
         .key_out    (key_chain[j+1]),
         .pos_out    (pos_chain[j+1]),
         .cmd        (cmd),
         .cmd_idx    (cmd_idx),
         .count      (count_ff),
         .wdata      (key_ff),
         .entry_next (next_entry),
         .entry_out  (entry_q[j])
      );
   end

   // Control.
   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign do_finish  = (state_ff == ST_FINISH) && out_free;
   assign full       = (CMP_W'(count_ff) >= CMP_W'(capacity_ff)) || (count_ff >= DEPTH_CNT);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if ((req_type == OP_REMOVE) || (req_type == OP_SEARCH)) begin
                  state_in = ST_WALK;
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_WALK: begin
            if (tok_chain[DEPTH].valid) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      status_in    = ST_OK;
      result_pos   = '0;
      count_in     = count_ff;
      cmd.write_en = 1'b0;
      cmd.shift_en = 1'b0;
      cmd_idx      = pos_ff;
      unique case (op_ff)
         OP_APPEND: begin
            cmd_idx = count_ff[IDX_W-1:0];
            if (key_ff == '0) begin
               status_in = ST_NULL;
            end else if (full) begin
               status_in = ST_FULL;
            end else begin
               result_pos   = count_ff[IDX_W-1:0];
               count_in     = count_ff + CNT_W'(1);
               cmd.write_en = do_finish;
            end
         end
         OP_REMOVE: begin
            if (found_ff) begin
               result_pos   = pos_ff;
               count_in     = count_ff - CNT_W'(1);
               cmd.shift_en = do_finish;
            end else begin
               status_in = ST_NOT_FOUND;
            end
         end
         OP_SEARCH: begin
            if (found_ff) begin
               result_pos = pos_ff;
            end else begin
               status_in = ST_NOT_FOUND;
            end
         end
         default: ;
      endcase
      over_warn_in = (CMP_W'(count_in) > CMP_W'(warn_ff));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         launch_ff    <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         launch_ff <= req_accept && ((req_type == OP_REMOVE) || (req_type == OP_SEARCH));
         if (do_finish) begin
            count_ff     <= count_in;
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         op_ff  <= req_type;
         key_ff <= HANDLE_BITS'(req_handle);
      end
      if (req_accept) begin
         found_ff <= 1'b0;
      end else if (tok_chain[DEPTH].valid) begin
         found_ff <= tok_chain[DEPTH].found;
         pos_ff   <= pos_chain[DEPTH];
      end
      if (do_finish) begin
         rsp_status_ff    <= status_in;
         rsp_position_ff  <= POS_W'(result_pos);
         rsp_count_ff     <= COUNT_W'(count_in);
         rsp_over_warn_ff <= over_warn_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_position  = rsp_position_ff;
   assign rsp_count     = rsp_count_ff;
   assign rsp_over_warn = rsp_over_warn_ff;

`ifndef SYNTHESIS
   a_token_in_walk : assert property (@(posedge clock) disable iff (reset)
      tok_chain[DEPTH].valid |-> (state_ff == ST_WALK))
      else $error("search token left the row outside the walk state");

   a_launch_in_walk : assert property (@(posedge clock) disable iff (reset)
      launch_ff |-> (state_ff == ST_WALK))
      else $error("token launched outside the walk state");

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_CNT)
      else $error("entry count above the row length");

   a_remove_count : assert property (@(posedge clock) disable iff (reset)
      (do_finish && (op_ff == OP_REMOVE) && found_ff) |=>
         (count_ff == $past(count_ff) - CNT_W'(1)))
      else $error("remove did not shorten the list by one");
`endif

endmodule

FILE: rtl/ohl_cell.sv
// One list cell: holds one entry and passes the search token to its neighbour.
module ohl_cell #(
   parameter int CELL_IDX    = 0,
   parameter int IDX_W       = 10,
   parameter int CNT_W       = 11,
   parameter int HANDLE_BITS = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  ohl_pkg::tok_type       tok_in,
   input  logic [HANDLE_BITS-1:0] key_in,
   input  logic [IDX_W-1:0]       pos_in,
   output ohl_pkg::tok_type       tok_out,
   output logic [HANDLE_BITS-1:0] key_out,
   output logic [IDX_W-1:0]       pos_out,
   input  ohl_pkg::cmd_type       cmd,
   input  logic [IDX_W-1:0]       cmd_idx,
   input  logic [CNT_W-1:0]       count,
   input  logic [HANDLE_BITS-1:0] wdata,
   input  logic [HANDLE_BITS-1:0] entry_next,
   output logic [HANDLE_BITS-1:0] entry_out
);
   import ohl_pkg::*;

   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);
   localparam logic [CNT_W-1:0] MY_CNT = CNT_W'(CELL_IDX);

   tok_type                tok_ff;
   tok_type                tok_in_next;
   logic [HANDLE_BITS-1:0] key_ff;
   logic [IDX_W-1:0]       pos_ff;
   logic [IDX_W-1:0]       pos_in_next;
   logic [HANDLE_BITS-1:0] entry_ff;
   logic                   hit;

   assign hit = tok_in.valid && !tok_in.found && (MY_CNT < count) && (entry_ff == key_in);

   always_comb begin
      tok_in_next.valid = tok_in.valid;
      tok_in_next.found = tok_in.found | hit;
      pos_in_next       = hit ? MY_IDX : pos_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff <= '0;
      end else begin
         tok_ff <= tok_in_next;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      pos_ff <= pos_in_next;
   end

   always_ff @(posedge clock) begin
      if (cmd.write_en && (cmd_idx == MY_IDX)) begin
         entry_ff <= wdata;
      end else if (cmd.shift_en && (MY_IDX >= cmd_idx)) begin
         entry_ff <= entry_next;
      end
   end

   assign tok_out   = tok_ff;
   assign key_out   = key_ff;
   assign pos_out   = pos_ff;
   assign entry_out = entry_ff;

endmodule
